@@ rtl/mlre_pkg.sv @@
// Shared types, codes and sizing constants of the mask line run extractor.
package mlre_pkg;

  // Line sizing and stencil half width
  localparam int MAX_LINE   = 1024;
  localparam int HALF_ORDER = 2;

  // Interior position counter holds 0..MAX_LINE; run indices hold 0..MAX_LINE-1
  localparam int POS_W  = $clog2(MAX_LINE + 1);
  localparam int IDX_W  = $clog2(MAX_LINE);
  // Non-hole span, ghost extension included
  localparam int SPAN_W = $clog2(MAX_LINE + HALF_ORDER + 1);

  // Grid index width of the register and the result fields
  localparam int GRID_W = 12;

  // Result buffer; depth is a power of two
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_INDEX_BASE = 1'b0;

  // Mask classes
  localparam logic [1:0] CLS_HOLE   = 2'd0;
  localparam logic [1:0] CLS_INTERP = 2'd1;
  localparam logic [1:0] CLS_DISC   = 2'd2;

  // Point roles
  localparam logic [1:0] ROLE_LEAD  = 2'd0;
  localparam logic [1:0] ROLE_INT   = 2'd1;
  localparam logic [1:0] ROLE_TRAIL = 2'd2;

  // Run kinds
  localparam logic [1:0] KIND_DISC    = 2'd0;
  localparam logic [1:0] KIND_NONHOLE = 2'd1;
  localparam logic [1:0] KIND_HOLE    = 2'd2;

  // Run status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FEW_PHYS   = 2'd1;
  localparam logic [1:0] ST_FEW_VALID  = 2'd2;

  // Line phase
  typedef enum logic [2:0] {
    PH_LEAD  = 3'b001,
    PH_INT   = 3'b010,
    PH_TRAIL = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] mask_class;
    logic [1:0] point_role;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               run_kind;
    logic signed [GRID_W-1:0] run_first;
    logic signed [GRID_W-1:0] run_final;
    logic [1:0]               status;
    logic                     last_of_item;
  } out_word_t;

endpackage

@@ rtl/mask_line_run_extractor_core.sv @@
// Top level of the mask line run extractor: run detection and result buffer.
//
// The block takes one grid line of mask points, one word per point: leading
// ghost points, the interior points, then trailing ghost points, the last word
// of the line carrying end_of_line. Over the interior points it reports every
// maximal run of discretisation points (kind 0), of non-hole points (kind 1)
// and of hole points (kind 2) as grid indices index_base + position, wrapped
// to 12 bits. A discretisation run with fewer than HALF_ORDER+1 points gets
// status 1; a non-hole run whose span, extended by HALF_ORDER ghost points
// where it touches the line end (else where it starts on the first interior
// point), is below 2*HALF_ORDER+1 and that holds a discretisation point, ghost
// points included, gets status 2. One input word causes zero, one or two
// result words; the last of them carries last_of_item, and within a word the
// order is discretisation, non-hole, hole, except at the line end where the
// non-hole run comes last. Timing: an input word is registered at acceptance
// and resolved from that register; its results enter an eight-entry result
// buffer at the following edge, and out_data shows the oldest buffered word.
// in_ready is taken straight from registers and stays high while the buffer
// can absorb two more words per word in flight, so one input word per cycle
// is accepted as long as the result port keeps up with the results; the
// result port moves one word per cycle. index_base is written over the APB
// port at byte address 0; the user must write it only while the block is
// idle, and the block itself does not enforce this. No clearing pass runs
// after reset.
module mask_line_run_extractor_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mlre_pkg::in_word_t                  in_data,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output mlre_pkg::out_word_t                 out_data,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mlre_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mlre_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mlre_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IDX_W  = mlre_pkg::IDX_W;
  localparam int POS_W  = mlre_pkg::POS_W;
  localparam int SPAN_W = mlre_pkg::SPAN_W;
  localparam int GRID_W = mlre_pkg::GRID_W;
  localparam int PTR_W  = mlre_pkg::RES_PTR_W;
  localparam int CNT_W  = mlre_pkg::RES_CNT_W;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [GRID_W-1:0] index_base_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_base_r <= '0;
    end else if (cfg_wr && (paddr[2] == mlre_pkg::REG_INDEX_BASE)) begin
      index_base_r <= pwdata[GRID_W-1:0];
    end
  end

  // Sign-extend the register on read; other addresses read as zero
  always_comb begin
    if (paddr[2] == mlre_pkg::REG_INDEX_BASE) begin
      prdata = {{(mlre_pkg::CFG_DATA_W-GRID_W){index_base_r[GRID_W-1]}}, index_base_r};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               in_acc;
  logic               stage_v_r;
  mlre_pkg::in_word_t stage_r;
  logic [CNT_W-1:0]   count_r;

  assign in_acc = in_valid & in_ready;

  // Hold off input while the buffer could not take two words for the word in
  // the stage plus two for the new one
  assign in_ready = (count_r + (stage_v_r ? CNT_W'(2) : CNT_W'(0)))
                    <= CNT_W'(mlre_pkg::RES_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------------
  mlre_pkg::phase_t phase_r,      phase_nxt;
  logic [POS_W-1:0] pos_r,        pos_nxt;
  logic [1:0]       prev_r,       prev_nxt;
  logic [IDX_W-1:0] disc_start_r, disc_start_nxt;
  logic [IDX_W-1:0] nh_start_r,   nh_start_nxt;
  logic [IDX_W-1:0] hole_start_r, hole_start_nxt;
  logic             nh_disc_r,    nh_disc_nxt;
  logic             lead_gd_r,    lead_gd_nxt;
  logic             trail_gd_r,   trail_gd_nxt;
  logic             pend_r,       pend_nxt;

  // Grid index of a line position
  function automatic logic [GRID_W-1:0] grid_idx(input logic [GRID_W-1:0] base,
                                                 input logic [IDX_W-1:0]  p);
    grid_idx = base + GRID_W'(p);
  endfunction

  function automatic logic [1:0] disc_status(input logic [IDX_W-1:0] first,
                                             input logic [IDX_W-1:0] final_p);
    logic [IDX_W-1:0] diff;
    diff = final_p - first;
    disc_status = (diff < IDX_W'(mlre_pkg::HALF_ORDER)) ? mlre_pkg::ST_FEW_PHYS
                                                         : mlre_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] nh_status(input logic [IDX_W-1:0] first,
                                           input logic [IDX_W-1:0] final_p,
                                           input logic             at_end,
                                           input logic             has_disc,
                                           input logic             lead_gd,
                                           input logic             trail_gd);
    logic [SPAN_W-1:0] span;
    logic              any;
    span = SPAN_W'(final_p) - SPAN_W'(first) + SPAN_W'(1);
    any  = has_disc;
    if (at_end) begin
      span = span + SPAN_W'(mlre_pkg::HALF_ORDER);
      any  = any | trail_gd;
    end else if (first == '0) begin
      span = span + SPAN_W'(mlre_pkg::HALF_ORDER);
      any  = any | lead_gd;
    end
    nh_status = ((span < SPAN_W'(2 * mlre_pkg::HALF_ORDER + 1)) && any)
                ? mlre_pkg::ST_FEW_VALID : mlre_pkg::ST_OK;
  endfunction

  // Result words of the staged item
  mlre_pkg::out_word_t res [2];
  logic [1:0]          res_n;

  logic [1:0]       cls;
  logic             is_disc, is_hole, eol;
  logic             pc_disc, pc_hole, p_nz;
  logic [IDX_W-1:0] p_idx, last_idx;
  mlre_pkg::phase_t eff_ph;

  assign cls      = stage_r.mask_class;
  assign is_disc  = cls[1];                     // class three counts as discretisation
  assign is_hole  = (cls == mlre_pkg::CLS_HOLE);
  assign eol      = stage_r.end_of_line;
  assign pc_disc  = (prev_r == mlre_pkg::CLS_DISC);
  assign pc_hole  = (prev_r == mlre_pkg::CLS_HOLE);
  assign p_nz     = (pos_r != '0);
  assign p_idx    = pos_r[IDX_W-1:0];
  assign last_idx = p_idx - IDX_W'(1);

  // Effective role: end of line and role three act as trailing ghost, and the
  // phase never steps back
  always_comb begin
    if (eol || stage_r.point_role[1] || (phase_r == mlre_pkg::PH_TRAIL)) begin
      eff_ph = mlre_pkg::PH_TRAIL;
    end else if ((stage_r.point_role == mlre_pkg::ROLE_INT) ||
                 (phase_r == mlre_pkg::PH_INT)) begin
      eff_ph = mlre_pkg::PH_INT;
    end else begin
      eff_ph = mlre_pkg::PH_LEAD;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    prev_nxt       = prev_r;
    disc_start_nxt = disc_start_r;
    nh_start_nxt   = nh_start_r;
    hole_start_nxt = hole_start_r;
    nh_disc_nxt    = nh_disc_r;
    lead_gd_nxt    = lead_gd_r;
    trail_gd_nxt   = trail_gd_r;
    pend_nxt       = pend_r;
    res_n          = 2'd0;
    for (int i = 0; i < 2; i++) begin
      res[i] = '0;
    end

    unique case (eff_ph)
      mlre_pkg::PH_LEAD: begin
        phase_nxt = mlre_pkg::PH_LEAD;
        if (is_disc) begin
          lead_gd_nxt = 1'b1;
        end
      end

      mlre_pkg::PH_INT: begin
        phase_nxt = mlre_pkg::PH_INT;
        // drop points beyond the line capacity
        if (pos_r < POS_W'(mlre_pkg::MAX_LINE)) begin
          if (p_nz && pc_disc && !is_disc) begin
            res[res_n[0]] = '{mlre_pkg::KIND_DISC,
                              grid_idx(index_base_r, disc_start_r),
                              grid_idx(index_base_r, last_idx),
                              disc_status(disc_start_r, last_idx), 1'b0};
            res_n = res_n + 2'd1;
          end
          if (p_nz && !pc_hole && is_hole) begin
            res[res_n[0]] = '{mlre_pkg::KIND_NONHOLE,
                              grid_idx(index_base_r, nh_start_r),
                              grid_idx(index_base_r, last_idx),
                              nh_status(nh_start_r, last_idx, 1'b0, nh_disc_r,
                                        lead_gd_r, trail_gd_r), 1'b0};
            res_n = res_n + 2'd1;
          end
          if (p_nz && pc_hole && !is_hole) begin
            res[res_n[0]] = '{mlre_pkg::KIND_HOLE,
                              grid_idx(index_base_r, hole_start_r),
                              grid_idx(index_base_r, last_idx),
                              mlre_pkg::ST_OK, 1'b0};
            res_n = res_n + 2'd1;
          end
          if (is_disc && (!p_nz || !pc_disc)) begin
            disc_start_nxt = p_idx;
          end
          if (!is_hole && (!p_nz || pc_hole)) begin
            nh_start_nxt = p_idx;
            nh_disc_nxt  = 1'b0;
          end
          if (is_hole && (!p_nz || !pc_hole)) begin
            hole_start_nxt = p_idx;
          end
          if (is_disc) begin
            nh_disc_nxt = 1'b1;
          end
          prev_nxt = is_disc ? mlre_pkg::CLS_DISC : cls;
          pos_nxt  = pos_r + POS_W'(1);
        end
      end

      mlre_pkg::PH_TRAIL: begin
        // close the open discretisation and hole runs on the first trailing ghost
        if (phase_r != mlre_pkg::PH_TRAIL) begin
          phase_nxt = mlre_pkg::PH_TRAIL;
          if (p_nz) begin
            if (pc_disc) begin
              res[res_n[0]] = '{mlre_pkg::KIND_DISC,
                                grid_idx(index_base_r, disc_start_r),
                                grid_idx(index_base_r, last_idx),
                                disc_status(disc_start_r, last_idx), 1'b0};
              res_n = res_n + 2'd1;
            end
            if (pc_hole) begin
              res[res_n[0]] = '{mlre_pkg::KIND_HOLE,
                                grid_idx(index_base_r, hole_start_r),
                                grid_idx(index_base_r, last_idx),
                                mlre_pkg::ST_OK, 1'b0};
              res_n = res_n + 2'd1;
            end else begin
              pend_nxt = 1'b1;
            end
          end
        end
        if (is_disc) begin
          trail_gd_nxt = 1'b1;
        end
        if (eol) begin
          // the non-hole run at the line end sees this word's ghost class
          if (pend_nxt && p_nz) begin
            res[res_n[0]] = '{mlre_pkg::KIND_NONHOLE,
                              grid_idx(index_base_r, nh_start_r),
                              grid_idx(index_base_r, last_idx),
                              nh_status(nh_start_r, last_idx, 1'b1, nh_disc_r,
                                        lead_gd_r, trail_gd_nxt), 1'b0};
            res_n = res_n + 2'd1;
          end
          phase_nxt      = mlre_pkg::PH_LEAD;
          pos_nxt        = '0;
          prev_nxt       = mlre_pkg::CLS_HOLE;
          disc_start_nxt = '0;
          nh_start_nxt   = '0;
          hole_start_nxt = '0;
          nh_disc_nxt    = 1'b0;
          lead_gd_nxt    = 1'b0;
          trail_gd_nxt   = 1'b0;
          pend_nxt       = 1'b0;
        end
      end

      default: begin
        phase_nxt = mlre_pkg::PH_LEAD;
      end
    endcase

    // mark the last word of the item
    if (res_n == 2'd1) begin
      res[0].last_of_item = 1'b1;
    end else if (res_n == 2'd2) begin
      res[1].last_of_item = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mlre_pkg::PH_LEAD;
      pos_r        <= '0;
      prev_r       <= mlre_pkg::CLS_HOLE;
      disc_start_r <= '0;
      nh_start_r   <= '0;
      hole_start_r <= '0;
      nh_disc_r    <= 1'b0;
      lead_gd_r    <= 1'b0;
      trail_gd_r   <= 1'b0;
      pend_r       <= 1'b0;
    end else if (stage_v_r) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      prev_r       <= prev_nxt;
      disc_start_r <= disc_start_nxt;
      nh_start_r   <= nh_start_nxt;
      hole_start_r <= hole_start_nxt;
      nh_disc_r    <= nh_disc_nxt;
      lead_gd_r    <= lead_gd_nxt;
      trail_gd_r   <= trail_gd_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer
  // ---------------------------------------------------------------------------
  mlre_pkg::out_word_t buf_mem [mlre_pkg::RES_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [1:0]          push_n;
  logic                pop;

  assign push_n    = stage_v_r ? res_n : 2'd0;
  assign out_valid = (count_r != '0);
  assign out_data  = buf_mem[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  assign count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      buf_mem[wr_ptr_r] <= res[0];
    end
    if (push_n == 2'd2) begin
      buf_mem[wr_ptr_r + PTR_W'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_buf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(mlre_pkg::RES_DEPTH))
    else $error("result buffer overflow");

  a_buf_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0])
    else $error("result buffer pointers disagree with count");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(mlre_pkg::MAX_LINE))
    else $error("line position beyond capacity");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && eol) |=> ((pos_r == '0) && (phase_r == mlre_pkg::PH_LEAD) && !pend_r))
    else $error("line state not cleared after end of line");

endmodule
